/* rtl/rcmd_pkg.sv */
// Shared types, constants and helpers of the command parser and motor drive.
`timescale 1ns / 1ps
package rcmd_pkg;
	localparam int LineBufDefault = 128;
	localparam logic [15:0] GainReset = 16'd5243;
	localparam logic [20:0] BandReset = 21'd131072;
	localparam logic [13:0] ServoCentre = 14'd1228;
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;
	localparam logic [3:0] BRIDGE_FWD = 4'b1001;
	localparam logic [3:0] BRIDGE_REV = 4'b0110;
	localparam logic [3:0] BRIDGE_OFF = 4'b0000;
	localparam logic [15:0] NumMax = 16'd32767;
	localparam int ServoSteps = 81;

	typedef enum logic [2:0] {
		PH_LETTER, PH_COLON, PH_LEAD, PH_SIGN, PH_DIGITS, PH_STOP
	} phase_t;

	typedef struct packed {
		logic start;
		logic byte_step;
		logic line_end;
		logic close;
		logic tick_a;
		logic tick_b;
		logic tick_c;
		logic tick_d;
		logic tick_e;
	} dp_cmd_t;

	typedef struct packed {
		logic servo_flag;
		logic speed_flag;
	} dp_stat_t;

	// Servo duty for a clamped angle of -40..40 (index angle+40).
	function automatic logic [13:0] servo_of(input logic [6:0] idx);
		int a;
		int p;
		a = int'(idx) - 40;
		p = 1500 + (a * 1000) / 90;
		return 14'((p * 16384) / 20000);
	endfunction

	function automatic logic [ServoSteps*14-1:0] servo_table();
		logic [ServoSteps*14-1:0] t;
		t = '0;
		for (int i = 0; i < ServoSteps; i++)
			t[i*14 +: 14] = servo_of(7'(i));
		return t;
	endfunction

	localparam logic [ServoSteps*14-1:0] ServoTable = servo_table();
endpackage

/* rtl/rcmd_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface rcmd_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface rcmd_out_if;
	logic valid;
	logic ready;
	logic [13:0] servo_duty;
	logic servo_updated;
	logic [7:0] motor_duty;
	logic [3:0] bridge_pins;
	logic speed_updated;
	modport source (output valid, servo_duty, servo_updated, motor_duty, bridge_pins,
		speed_updated, input ready);
	modport sink (input valid, servo_duty, servo_updated, motor_duty, bridge_pins,
		speed_updated, output ready);
endinterface

/* rtl/rcmd_ctrl.sv */
// Controller state machine sequencing requests through the datapath.
`timescale 1ns / 1ps
module rcmd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_cmd,
	input logic [7:0] in_byte,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output rcmd_pkg::dp_cmd_t dp_cmd
);
	import rcmd_pkg::*;
	typedef enum logic [2:0] {S_IDLE, S_T1, S_T2, S_T3, S_T4, S_OUT} state_t;
	state_t state_q;
	logic take;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = state_q == S_OUT;
	assign take = in_valid && in_ready;

	always_comb begin
		dp_cmd = '0;
		if (take) begin
			dp_cmd.start = 1'b1;
			dp_cmd.byte_step = in_cmd == CMD_BYTE && in_byte != 8'h0A && in_byte != 8'h0D;
			dp_cmd.line_end = in_cmd == CMD_BYTE && (in_byte == 8'h0A || in_byte == 8'h0D);
			dp_cmd.close = in_cmd == CMD_CLOSE;
			dp_cmd.tick_a = in_cmd == CMD_TICK;
		end
		dp_cmd.tick_b = state_q == S_T1;
		dp_cmd.tick_c = state_q == S_T2;
		dp_cmd.tick_d = state_q == S_T3;
		dp_cmd.tick_e = state_q == S_T4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (take) begin
						state_q <= (in_cmd == CMD_TICK) ? S_T1 : S_OUT;
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: state_q <= S_OUT;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/rcmd_dp.sv */
// Datapath: line parser, servo and target registers, two-stage speed filter.
`timescale 1ns / 1ps
module rcmd_dp #(
	parameter int LINE_BUF = rcmd_pkg::LineBufDefault
) (
	input logic clk,
	input logic arst_n,
	input rcmd_pkg::dp_cmd_t dp_cmd,
	input logic [7:0] in_byte,
	input logic [15:0] gain,
	input logic [20:0] band,
	output rcmd_pkg::dp_stat_t stat,
	output logic [13:0] servo_duty,
	output logic [7:0] motor_duty,
	output logic [3:0] bridge_pins
);
	import rcmd_pkg::*;
	localparam int LW = $clog2(LINE_BUF);

	logic [LW-1:0] len_q;
	phase_t phase_q;
	logic [2:0] done_q;
	logic [15:0] acc_q;
	logic neg_q;
	logic signed [15:0] val_q [4];
	logic signed [15:0] target_q;
	logic signed [33:0] s1_q, s2_q;
	logic signed [34:0] diff_c;
	logic signed [51:0] prod_q;
	logic [13:0] servo_q;
	logic [7:0] drive_q;
	logic [3:0] bridge_q;
	logic servo_flag_q, speed_flag_q;

	logic is_dig, is_blank;
	logic [3:0] dig;
	logic [19:0] acc_next;
	logic [7:0] letter;
	logic signed [15:0] fin_val;
	logic [2:0] done_fin;
	logic signed [15:0] v0, v1, v2, v3;
	logic signed [7:0] ac, bc, net;
	logic signed [23:0] tprod;
	logic signed [15:0] tsat;
	logic [6:0] sidx;
	logic signed [33:0] step_v;
	logic [33:0] mag;
	logic [43:0] dprod;

	assign is_dig = in_byte >= 8'h30 && in_byte <= 8'h39;
	assign is_blank = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0B || in_byte == 8'h0C;
	assign dig = 4'(in_byte - 8'h30);
	assign acc_next = {4'd0, acc_q} * 20'd10 + {16'd0, dig};
	assign fin_val = neg_q ? -$signed(acc_q) : $signed(acc_q);
	assign done_fin = (done_q < 3'd4) ? done_q + 3'd1 : done_q;

	always_comb begin
		case (done_q[1:0])
			2'd0: letter = 8'h53;
			2'd1: letter = 8'h47;
			2'd2: letter = 8'h41;
			default: letter = 8'h42;
		endcase
	end

	// Values as seen at line end, including a pending field.
	always_comb begin
		v0 = val_q[0]; v1 = val_q[1]; v2 = val_q[2]; v3 = val_q[3];
		if (phase_q == PH_DIGITS) begin
			case (done_q[1:0])
				2'd0: v0 = fin_val;
				2'd1: v1 = fin_val;
				2'd2: v2 = fin_val;
				default: v3 = fin_val;
			endcase
		end
	end

	assign ac = (v2 < 0) ? 8'sd0 : (v2 > 100) ? 8'sd100 : 8'(v2);
	assign bc = (v3 < 0) ? 8'sd0 : (v3 > 100) ? 8'sd100 : 8'(v3);
	assign net = (ac > bc) ? ac - bc : 8'sd0;
	assign tprod = 24'(net) * 24'(v1);
	assign tsat = (tprod > 24'sd32767) ? 16'sd32767 :
		(tprod < -24'sd32767) ? -16'sd32767 : tprod[15:0];
	assign sidx = (v0 < -40) ? 7'd0 : (v0 > 40) ? 7'd80 : 7'(v0 + 16'sd40);

	assign diff_c = dp_cmd.tick_a ? 35'($signed({target_q, 16'd0})) - 35'(s1_q) :
		35'(s1_q) - 35'(s2_q);
	assign step_v = 34'(prod_q >>> 16);
	assign mag = s2_q[33] ? 34'(-s2_q) : s2_q;
	assign dprod = 44'(mag) * 44'd653;

	always_ff @(posedge clk) begin
		if (dp_cmd.tick_a || dp_cmd.tick_c)
			prod_q <= 52'($signed({1'b0, gain})) * 52'(diff_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			phase_q <= PH_LETTER;
			done_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			for (int i = 0; i < 4; i++) val_q[i] <= '0;
			target_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			servo_q <= ServoCentre;
			drive_q <= '0;
			bridge_q <= BRIDGE_OFF;
			servo_flag_q <= 1'b0;
			speed_flag_q <= 1'b0;
		end else begin
			if (dp_cmd.start) begin
				servo_flag_q <= 1'b0;
				speed_flag_q <= 1'b0;
			end
			if (dp_cmd.close) begin
				target_q <= '0;
				speed_flag_q <= 1'b1;
			end
			if (dp_cmd.line_end && len_q != '0) begin
				if (phase_q == PH_DIGITS) val_q[done_q[1:0]] <= fin_val;
				if ((phase_q == PH_DIGITS ? done_fin : done_q) >= 3'd1) begin
					servo_q <= ServoTable[int'(sidx) * 14 +: 14];
					servo_flag_q <= 1'b1;
				end
				if ((phase_q == PH_DIGITS ? done_fin : done_q) >= 3'd4) begin
					target_q <= tsat;
					speed_flag_q <= 1'b1;
				end
				len_q <= '0;
				phase_q <= PH_LETTER;
				done_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
			end
			if (dp_cmd.byte_step && len_q < LW'(LINE_BUF - 1)) begin
				len_q <= len_q + 1'b1;
				if (in_byte == 8'h00) begin
					if (phase_q == PH_DIGITS) begin
						val_q[done_q[1:0]] <= fin_val;
						done_q <= done_fin;
						acc_q <= '0;
						neg_q <= 1'b0;
					end
					phase_q <= PH_STOP;
				end else begin
					unique case (phase_q)
						PH_LETTER: phase_q <= (done_q < 3'd4 && in_byte == letter) ?
							PH_COLON : PH_STOP;
						PH_COLON: begin
							if (in_byte == 8'h3A) begin
								phase_q <= PH_LEAD;
								acc_q <= '0;
								neg_q <= 1'b0;
							end else phase_q <= PH_STOP;
						end
						PH_LEAD: begin
							if (is_blank) begin
							end else if (in_byte == 8'h2B || in_byte == 8'h2D) begin
								neg_q <= in_byte == 8'h2D;
								phase_q <= PH_SIGN;
							end else if (is_dig) begin
								acc_q <= {12'd0, dig};
								phase_q <= PH_DIGITS;
							end else phase_q <= PH_STOP;
						end
						PH_SIGN: begin
							if (is_dig) begin
								acc_q <= {12'd0, dig};
								phase_q <= PH_DIGITS;
							end else phase_q <= PH_STOP;
						end
						PH_DIGITS: begin
							if (is_dig) begin
								acc_q <= (acc_next > 20'(NumMax)) ? NumMax : acc_next[15:0];
							end else begin
								val_q[done_q[1:0]] <= fin_val;
								done_q <= done_fin;
								acc_q <= '0;
								neg_q <= 1'b0;
								phase_q <= (done_fin < 3'd4 && in_byte == 8'h2C) ?
									PH_LETTER : PH_STOP;
							end
						end
						default: phase_q <= PH_STOP;
					endcase
				end
			end
			if (dp_cmd.tick_b) s1_q <= s1_q + step_v;
			if (dp_cmd.tick_d) s2_q <= s2_q + step_v;
			if (dp_cmd.tick_e) begin
				if (s2_q > $signed({13'd0, band})) begin
					bridge_q <= BRIDGE_FWD;
					drive_q <= (dprod[43:24] > 20'd255) ? 8'd255 : dprod[31:24];
				end else if (s2_q < -$signed({13'd0, band})) begin
					bridge_q <= BRIDGE_REV;
					drive_q <= (dprod[43:24] > 20'd255) ? 8'd255 : dprod[31:24];
				end else begin
					bridge_q <= BRIDGE_OFF;
					drive_q <= '0;
				end
			end
		end
	end

	assign stat.servo_flag = servo_flag_q;
	assign stat.speed_flag = speed_flag_q;
	assign servo_duty = servo_q;
	assign motor_duty = drive_q;
	assign bridge_pins = bridge_q;
endmodule

/* rtl/rc_command_parser_motor_drive.sv */
// Top level of the RC command parser and motor drive.
// Sequencing: byte, close and unknown requests give a result in the cycle after acceptance; a
// tick passes through two gain multiplies, two filter updates and the bridge before its result.
// Throughput: one request per cycle for non-tick requests while results are taken; no request
// is taken while a tick is in progress; both filter stages share the 17x35 gain multiplier.
// Reset (arst_n low) clears parser, filters and outputs, servo to centre, registers to defaults.
`timescale 1ns / 1ps
module rc_command_parser_motor_drive #(
	parameter int LINE_BUF = rcmd_pkg::LineBufDefault
) (
	input logic clk,
	input logic arst_n,
	rcmd_in_if.sink in_ch,
	rcmd_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rcmd_pkg::*;
	localparam logic [2:0] ADDR_GAIN = 3'd0;
	localparam logic [2:0] ADDR_BAND = 3'd4;

	logic [15:0] gain_q;
	logic [20:0] band_q;
	dp_cmd_t dp_cmd;
	dp_stat_t stat;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
			band_q <= BandReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_GAIN: gain_q <= pwdata[15:0];
				ADDR_BAND: band_q <= pwdata[20:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			ADDR_GAIN: prdata = {16'd0, gain_q};
			ADDR_BAND: prdata = {11'd0, band_q};
			default: prdata = '0;
		endcase
	end

	rcmd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .in_byte(in_ch.data_byte),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.dp_cmd
	);

	rcmd_dp #(.LINE_BUF(LINE_BUF)) u_dp (
		.clk, .arst_n, .dp_cmd, .in_byte(in_ch.data_byte),
		.gain(gain_q), .band(band_q), .stat,
		.servo_duty(out_ch.servo_duty), .motor_duty(out_ch.motor_duty),
		.bridge_pins(out_ch.bridge_pins)
	);
	assign out_ch.servo_updated = stat.servo_flag;
	assign out_ch.speed_updated = stat.speed_flag;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.byte_step, dp_cmd.line_end, dp_cmd.close, dp_cmd.tick_a}))
		else $error("more than one datapath command");
	a_busy_tick: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.tick_a |=> !in_ch.ready && !out_ch.valid)
		else $error("accepting during tick");
	a_bridge: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.bridge_pins == BRIDGE_OFF |-> out_ch.motor_duty == 8'd0)
		else $error("duty while bridge off");
endmodule
